>>> rtl/core/atl_pkg.sv
// Shared types, token codes and byte classes of the assembler token lexer.
package atl_pkg;

  localparam int unsigned OFFSET_BITS_DEFAULT = 16;
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned PUNCT_COUNT = 11;

  localparam logic [4:0] KIND_IDENT      = 5'd0;
  localparam logic [4:0] KIND_NUMBER     = 5'd1;
  localparam logic [4:0] KIND_STRING     = 5'd2;
  localparam logic [4:0] KIND_PUNCT_BASE = 5'd3;
  localparam logic [4:0] KIND_BAD_BYTE   = 5'd14;
  localparam logic [4:0] KIND_UNCLOSED   = 5'd15;
  localparam logic [4:0] KIND_END        = 5'd16;

  localparam logic [7:0] CHAR_TAB        = 8'h09;
  localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_QUOTE      = 8'h22;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_ZERO       = 8'h30;
  localparam logic [7:0] CHAR_LOWER_X    = 8'h78;

  // Punctuation in kind order: = : , - . ( ) { } [ ]
  localparam logic [7:0] PUNCT_CHARS [PUNCT_COUNT] = '{
    8'h3D, 8'h3A, 8'h2C, 8'h2D, 8'h2E, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D
  };

  typedef enum logic [5:0] {
    MODE_START  = 6'b000001,
    MODE_IDENT  = 6'b000010,
    MODE_NUM    = 6'b000100,
    MODE_HEX    = 6'b001000,
    MODE_STRING = 6'b010000,
    MODE_ERROR  = 6'b100000
  } lex_mode_e;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] offset;
    logic [15:0] length;
    logic [7:0]  bad;
  } result_t;

  function automatic logic is_letter(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_decimal(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_hex_digit(logic [7:0] b);
    return is_decimal(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return b == CHAR_TAB || b == CHAR_NEWLINE || b == CHAR_SPACE;
  endfunction

  // Token kind of a punctuation byte, or the bad byte kind for anything else.
  function automatic logic [4:0] punct_kind(logic [7:0] b);
    logic [4:0] k;
    k = KIND_BAD_BYTE;
    for (int i = 0; i < PUNCT_COUNT; i++) begin
      if (b == PUNCT_CHARS[i]) begin
        k = KIND_PUNCT_BASE + 5'(i);
      end
    end
    return k;
  endfunction

endpackage

>>> rtl/core/assembler_token_lexer.sv
// Top level of the assembler token lexer: input register, lexer state and token buffer.
//
// The lexer takes one source byte per request and returns tokens as kind, start
// offset and length; each stream closes with an end token and the next byte starts
// a fresh stream at offset zero. A byte is latched in the input register, runs
// through combinational classification logic, and its tokens (zero to three) land
// in the token buffer together with the new lexer state. Bytes that give zero or
// one token flow at one byte per clock while out_stall_i is low. A byte that gives
// two or three tokens holds the buffer until its last token is taken; a byte with
// tokens of its own that comes meanwhile waits in the input register with
// in_stall_o raised, while a byte that gives no token never waits for the output
// side. run_last_o marks the last token of a byte. Offsets count in OFFSET_BITS
// bits and saturate at the top; the token ports carry their low 16 bits.
module assembler_token_lexer #(
  parameter int unsigned OFFSET_BITS = atl_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        stream_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  token_kind_o,
  output logic [15:0] token_offset_o,
  output logic [15:0] token_size_o,
  output logic [7:0]  offending_byte_o,
  output logic        run_last_o
);

  // Input register.
  logic       a_valid_q;
  logic [7:0] a_byte_q;
  logic       a_end_q;

  // Lexer state.
  atl_pkg::lex_mode_e     mode_q, mode_d;
  logic                   lead_zero_q, lead_zero_d;
  logic [OFFSET_BITS-1:0] begin_q, begin_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;

  // Token buffer: the tokens of one byte, sent out one per cycle while out_stall_i is low.
  atl_pkg::result_t res_q [atl_pkg::MAX_RESULTS];
  atl_pkg::result_t res_d [atl_pkg::MAX_RESULTS];
  logic [1:0]       cnt_q, cnt_d;
  logic [1:0]       idx_q;

  logic in_accept;
  logic out_take;
  logic buf_free;
  logic a_move;
  logic last_of_byte;

  atl_step #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_step (
    .mode_i       (mode_q),
    .lead_zero_i  (lead_zero_q),
    .begin_i      (begin_q),
    .pos_i        (pos_q),
    .data_byte_i  (a_byte_q),
    .stream_end_i (a_end_q),
    .mode_o       (mode_d),
    .lead_zero_o  (lead_zero_d),
    .begin_o      (begin_d),
    .pos_o        (pos_d),
    .res_o        (res_d),
    .count_o      (cnt_d)
  );

  assign last_of_byte = (idx_q == cnt_q - 2'd1);
  assign out_valid_o  = (cnt_q != 2'd0);
  assign out_take     = out_valid_o && !out_stall_i;
  // The buffer can take a new byte's tokens when it is empty or its last token leaves now.
  assign buf_free     = !out_valid_o || (out_take && last_of_byte);
  // A byte without tokens only updates the state, so it never waits for the output.
  assign a_move       = a_valid_q && (cnt_d == 2'd0 || buf_free);
  assign in_stall_o   = a_valid_q && !a_move;
  assign in_accept    = in_valid_i && !in_stall_o;

  assign token_kind_o     = res_q[idx_q].kind;
  assign token_offset_o   = res_q[idx_q].offset;
  assign token_size_o     = res_q[idx_q].length;
  assign offending_byte_o = res_q[idx_q].bad;
  assign run_last_o       = last_of_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_accept) begin
      a_valid_q <= 1'b1;
    end else if (a_move) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_byte_q <= data_byte_i;
      a_end_q  <= stream_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= atl_pkg::MODE_START;
      lead_zero_q <= 1'b0;
      begin_q     <= '0;
      pos_q       <= '0;
    end else if (a_move) begin
      mode_q      <= mode_d;
      lead_zero_q <= lead_zero_d;
      begin_q     <= begin_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else if (a_move && cnt_d != 2'd0) begin
      cnt_q <= cnt_d;
      idx_q <= 2'd0;
    end else if (out_take) begin
      if (last_of_byte) begin
        cnt_q <= 2'd0;
        idx_q <= 2'd0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move && cnt_d != 2'd0) begin
      res_q <= res_d;
    end
  end

endmodule

>>> rtl/core/atl_step.sv
// One lexer step: next lexer state and the tokens caused by one source byte.
module atl_step #(
  parameter int unsigned OFFSET_BITS = atl_pkg::OFFSET_BITS_DEFAULT
) (
  input  atl_pkg::lex_mode_e    mode_i,
  input  logic                  lead_zero_i,
  input  logic [OFFSET_BITS-1:0] begin_i,
  input  logic [OFFSET_BITS-1:0] pos_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  stream_end_i,
  output atl_pkg::lex_mode_e    mode_o,
  output logic                  lead_zero_o,
  output logic [OFFSET_BITS-1:0] begin_o,
  output logic [OFFSET_BITS-1:0] pos_o,
  output atl_pkg::result_t      res_o [atl_pkg::MAX_RESULTS],
  output logic [1:0]            count_o
);

  localparam logic [OFFSET_BITS-1:0] PosMax = {OFFSET_BITS{1'b1}};

  logic [OFFSET_BITS-1:0] pos_next;
  logic                   consumed;
  logic [4:0]             pk;

  function automatic logic [15:0] to16(logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+15:0] e;
    e = (OFFSET_BITS + 16)'(v);
    return e[15:0];
  endfunction

  function automatic atl_pkg::result_t mk(logic [4:0] k, logic [OFFSET_BITS-1:0] off,
                                          logic [OFFSET_BITS-1:0] len, logic [7:0] bad);
    atl_pkg::result_t r;
    r.kind   = k;
    r.offset = to16(off);
    r.length = to16(len);
    r.bad    = bad;
    return r;
  endfunction

  always_comb begin
    mode_o      = mode_i;
    lead_zero_o = lead_zero_i;
    begin_o     = begin_i;
    consumed    = 1'b0;
    count_o     = 2'd0;
    pk          = atl_pkg::punct_kind(data_byte_i);
    for (int i = 0; i < atl_pkg::MAX_RESULTS; i++) begin
      res_o[i] = '0;
    end
    pos_next = (pos_i == PosMax) ? pos_i : pos_i + 1'b1;

    unique case (mode_i)
      atl_pkg::MODE_IDENT: begin
        if (atl_pkg::is_letter(data_byte_i) || atl_pkg::is_decimal(data_byte_i) ||
            data_byte_i == atl_pkg::CHAR_UNDERSCORE) begin
          consumed = 1'b1;
        end else begin
          res_o[count_o] = mk(atl_pkg::KIND_IDENT, begin_i, pos_i - begin_i, 8'd0);
          count_o = count_o + 2'd1;
          mode_o = atl_pkg::MODE_START;
        end
      end
      atl_pkg::MODE_NUM: begin
        if (lead_zero_i && data_byte_i == atl_pkg::CHAR_LOWER_X) begin
          mode_o   = atl_pkg::MODE_HEX;
          consumed = 1'b1;
        end else if (atl_pkg::is_decimal(data_byte_i)) begin
          consumed = 1'b1;
        end else begin
          res_o[count_o] = mk(atl_pkg::KIND_NUMBER, begin_i, pos_i - begin_i, 8'd0);
          count_o = count_o + 2'd1;
          mode_o = atl_pkg::MODE_START;
        end
        lead_zero_o = 1'b0;
      end
      atl_pkg::MODE_HEX: begin
        if (atl_pkg::is_hex_digit(data_byte_i)) begin
          consumed = 1'b1;
        end else begin
          res_o[count_o] = mk(atl_pkg::KIND_NUMBER, begin_i, pos_i - begin_i, 8'd0);
          count_o = count_o + 2'd1;
          mode_o = atl_pkg::MODE_START;
        end
      end
      atl_pkg::MODE_STRING: begin
        if (data_byte_i == atl_pkg::CHAR_QUOTE) begin
          res_o[count_o] = mk(atl_pkg::KIND_STRING, begin_i, pos_i - begin_i, 8'd0);
          count_o = count_o + 2'd1;
          mode_o = atl_pkg::MODE_START;
        end
        consumed = 1'b1;
      end
      atl_pkg::MODE_ERROR: begin
        consumed = 1'b1;
      end
      default: begin
        mode_o = atl_pkg::MODE_START;
      end
    endcase

    // A byte that was not taken by the running token starts over from start mode.
    if (!consumed) begin
      if (atl_pkg::is_letter(data_byte_i)) begin
        mode_o  = atl_pkg::MODE_IDENT;
        begin_o = pos_i;
      end else if (atl_pkg::is_decimal(data_byte_i)) begin
        mode_o      = atl_pkg::MODE_NUM;
        begin_o     = pos_i;
        lead_zero_o = (data_byte_i == atl_pkg::CHAR_ZERO);
      end else if (data_byte_i == atl_pkg::CHAR_QUOTE) begin
        mode_o  = atl_pkg::MODE_STRING;
        begin_o = pos_next;
      end else if (!atl_pkg::is_space(data_byte_i)) begin
        if (pk == atl_pkg::KIND_BAD_BYTE) begin
          res_o[count_o] = mk(pk, pos_i, OFFSET_BITS'(1), data_byte_i);
          mode_o = atl_pkg::MODE_ERROR;
        end else begin
          res_o[count_o] = mk(pk, pos_i, OFFSET_BITS'(1), 8'd0);
        end
        count_o = count_o + 2'd1;
      end
    end

    if (stream_end_i) begin
      if (mode_o == atl_pkg::MODE_IDENT) begin
        res_o[count_o] = mk(atl_pkg::KIND_IDENT, begin_o, pos_next - begin_o, 8'd0);
        count_o = count_o + 2'd1;
      end else if (mode_o == atl_pkg::MODE_NUM || mode_o == atl_pkg::MODE_HEX) begin
        res_o[count_o] = mk(atl_pkg::KIND_NUMBER, begin_o, pos_next - begin_o, 8'd0);
        count_o = count_o + 2'd1;
      end else if (mode_o == atl_pkg::MODE_STRING) begin
        res_o[count_o] = mk(atl_pkg::KIND_UNCLOSED, begin_o, pos_next - begin_o, 8'd0);
        count_o = count_o + 2'd1;
      end
      res_o[count_o] = mk(atl_pkg::KIND_END, pos_next, '0, 8'd0);
      count_o     = count_o + 2'd1;
      mode_o      = atl_pkg::MODE_START;
      begin_o     = '0;
      lead_zero_o = 1'b0;
      pos_o       = '0;
    end else begin
      pos_o = pos_next;
    end
  end

endmodule
